// File: hw/rtl/csl_pkg.sv
// Package: token types, class codes and character helpers for the lexer.
`timescale 1ns / 1ps
package csl_pkg;

    localparam int WORD_MAX_DEF  = 256;
    localparam int QUOTE_MAX_DEF = 256;
    localparam int TOK_SLOTS     = 3;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_TEXT   = 2'd1;
    localparam logic [1:0] MODE_LETTER = 2'd2;
    localparam logic [1:0] MODE_HALT   = 2'd3;

    localparam logic [3:0] NF_NUM    = 4'b0001;
    localparam logic [3:0] NF_DOT    = 4'b0010;
    localparam logic [3:0] NF_BEFORE = 4'b0100;
    localparam logic [3:0] NF_AFTER  = 4'b1000;

    localparam logic [5:0] CL_IDENT  = 6'd0;
    localparam logic [5:0] CL_INT    = 6'd1;
    localparam logic [5:0] CL_FLOAT  = 6'd2;
    localparam logic [5:0] CL_CHAR   = 6'd3;
    localparam logic [5:0] CL_VOID   = 6'd4;
    localparam logic [5:0] CL_TEXT   = 6'd5;
    localparam logic [5:0] CL_LETTER = 6'd6;
    localparam logic [5:0] CL_BAR    = 6'd7;
    localparam logic [5:0] CL_SLASH  = 6'd9;
    localparam logic [5:0] CL_PLUS   = 6'd10;
    localparam logic [5:0] CL_MINUS  = 6'd12;
    localparam logic [5:0] CL_DOT    = 6'd13;
    localparam logic [5:0] CL_GT     = 6'd14;
    localparam logic [5:0] CL_LT     = 6'd16;
    localparam logic [5:0] CL_ASSIGN = 6'd18;
    localparam logic [5:0] CL_SEMI   = 6'd20;
    localparam logic [5:0] CL_COMMA  = 6'd21;
    localparam logic [5:0] CL_LPAREN = 6'd22;
    localparam logic [5:0] CL_RPAREN = 6'd23;
    localparam logic [5:0] CL_LBRACE = 6'd24;
    localparam logic [5:0] CL_RBRACE = 6'd25;
    localparam logic [5:0] CL_STAR   = 6'd26;
    localparam logic [5:0] CL_BANG   = 6'd27;
    localparam logic [5:0] CL_AMP    = 6'd29;
    localparam logic [5:0] CL_END    = 6'd31;
    localparam logic [5:0] CL_ERROR  = 6'd32;

    localparam logic [39:0] KW_INT   = 40'h00_0074_6E69;
    localparam logic [39:0] KW_CHAR  = 40'h00_7261_6863;
    localparam logic [39:0] KW_FLOAT = 40'h74_616F_6C66;
    localparam logic [39:0] KW_VOID  = 40'h00_6469_6F76;

    typedef struct packed {
        logic [5:0]  cls;
        logic [31:0] start;
        logic [7:0]  len;
        logic        last;
    } token_t;

    typedef struct packed {
        logic [7:0]  len;
        logic [31:0] start;
        logic [39:0] prefix;
        logic [3:0]  flags;
    } word_t;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"], "_"};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'd32, [8'd9:8'd13]};
    endfunction

    function automatic logic [7:0] pair_second(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            "|":     r = "|";
            "+":     r = "+";
            "&":     r = "&";
            ">", "<", "=", "!": r = "=";
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] single_class(input logic [7:0] c);
        logic [5:0] r;
        case (c)
            "|":     r = CL_BAR;
            "/":     r = CL_SLASH;
            "+":     r = CL_PLUS;
            "-":     r = CL_MINUS;
            ".":     r = CL_DOT;
            ">":     r = CL_GT;
            "<":     r = CL_LT;
            "=":     r = CL_ASSIGN;
            ";":     r = CL_SEMI;
            ",":     r = CL_COMMA;
            "(":     r = CL_LPAREN;
            ")":     r = CL_RPAREN;
            "{":     r = CL_LBRACE;
            "}":     r = CL_RBRACE;
            "*":     r = CL_STAR;
            "!":     r = CL_BANG;
            "&":     r = CL_AMP;
            default: r = CL_IDENT;
        endcase
        return r;
    endfunction

    function automatic word_t word_clear();
        word_t w;
        w.len    = 8'd0;
        w.start  = 32'd0;
        w.prefix = 40'd0;
        w.flags  = NF_NUM;
        return w;
    endfunction

    function automatic word_t add_char(input word_t w, input logic [7:0] c,
                                       input logic [31:0] pos, input logic [8:0] limit);
        word_t r;
        r = w;
        if ({1'b0, w.len} < limit - 9'd1) begin
            if (w.len == 8'd0) begin
                r.start = pos;
            end
            if (w.len < 8'd5) begin
                r.prefix[8 * w.len[2:0] +: 8] = c;
            end
            if (c == ".") begin
                if ((w.flags & NF_DOT) != 4'd0) begin
                    r.flags = w.flags & ~NF_NUM;
                end else begin
                    r.flags = w.flags | NF_DOT;
                end
            end else if (is_digit(c)) begin
                r.flags = w.flags | (((w.flags & NF_DOT) != 4'd0) ? NF_AFTER : NF_BEFORE);
            end else begin
                r.flags = w.flags & ~NF_NUM;
            end
            r.len = w.len + 8'd1;
        end
        return r;
    endfunction

    function automatic logic [5:0] word_class(input word_t w);
        logic [5:0] r;
        r = CL_IDENT;
        if (w.len == 8'd3 && w.prefix == KW_INT) begin
            r = CL_INT;
        end else if (w.len == 8'd4 && w.prefix == KW_CHAR) begin
            r = CL_CHAR;
        end else if (w.len == 8'd5 && w.prefix == KW_FLOAT) begin
            r = CL_FLOAT;
        end else if (w.len == 8'd4 && w.prefix == KW_VOID) begin
            r = CL_VOID;
        end else if ((w.flags & NF_NUM) != 4'd0) begin
            if ((w.flags & NF_DOT) == 4'd0) begin
                r = CL_INT;
            end else if ((w.flags & (NF_BEFORE | NF_AFTER)) != 4'd0) begin
                r = CL_FLOAT;
            end
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/csl_core.sv
// Lexer state and per-byte token decode.
`timescale 1ns / 1ps
module csl_core
    import csl_pkg::*;
#(
    parameter int WORD_MAX  = WORD_MAX_DEF,
    parameter int QUOTE_MAX = QUOTE_MAX_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  logic         kind,
    input  logic [7:0]   data_byte,
    output token_t       tok [TOK_SLOTS],
    output logic [1:0]   tok_cnt
);

    localparam logic [8:0] WLIM = 9'(WORD_MAX);
    localparam logic [8:0] QLIM = 9'(QUOTE_MAX);

    logic [1:0]  mode_reg, mode_next;
    logic [7:0]  psym_reg, psym_next;
    logic [31:0] poff_reg, poff_next;
    word_t       word_reg, word_next;
    logic [7:0]  qlen_reg, qlen_next;
    logic [31:0] qstart_reg, qstart_next;
    logic [31:0] pos_reg, pos_next;

    always_comb begin
        logic [1:0] n;
        logic [7:0] c;
        logic [7:0] closer;
        logic       consumed;
        word_t      w;
        n = 2'd0;
        c = data_byte;
        consumed = 1'b0;
        w = word_reg;
        closer = 8'd0;
        mode_next = mode_reg;
        psym_next = psym_reg;
        poff_next = poff_reg;
        qlen_next = qlen_reg;
        qstart_next = qstart_reg;
        pos_next = pos_reg;
        for (int i = 0; i < TOK_SLOTS; i++) begin
            tok[i] = '0;
        end
        if (mode_reg == MODE_HALT) begin
            n = 2'd0;
        end else if (kind) begin
            if (mode_reg == MODE_TEXT || mode_reg == MODE_LETTER) begin
                tok[n] = '{(mode_reg == MODE_TEXT) ? CL_TEXT : CL_LETTER,
                           qstart_reg, qlen_reg, 1'b0};
                n = n + 2'd1;
            end else begin
                if (w.len != 8'd0) begin
                    tok[n] = '{word_class(w), w.start, w.len, 1'b0};
                    n = n + 2'd1;
                    w = word_clear();
                end
                if (psym_reg != 8'd0) begin
                    tok[n] = '{single_class(psym_reg), poff_reg, 8'd1, 1'b0};
                    n = n + 2'd1;
                end
            end
            psym_next = 8'd0;
            tok[n] = '{CL_END, pos_reg, 8'd0, 1'b0};
            n = n + 2'd1;
            mode_next = MODE_HALT;
        end else if (mode_reg == MODE_TEXT || mode_reg == MODE_LETTER) begin
            closer = (mode_reg == MODE_TEXT) ? 8'h22 : 8'h27;
            if ({1'b0, qlen_reg} >= QLIM - 9'd1 || c == closer) begin
                tok[n] = '{(mode_reg == MODE_TEXT) ? CL_TEXT : CL_LETTER,
                           qstart_reg, qlen_reg, 1'b0};
                n = n + 2'd1;
                mode_next = MODE_NORMAL;
            end else begin
                qlen_next = qlen_reg + 8'd1;
            end
            pos_next = pos_reg + 32'd1;
        end else begin
            if (psym_reg == ".") begin
                if (is_digit(c)) begin
                    w = add_char(w, ".", poff_reg, WLIM);
                end else begin
                    if (w.len != 8'd0) begin
                        tok[n] = '{word_class(w), w.start, w.len, 1'b0};
                        n = n + 2'd1;
                        w = word_clear();
                    end
                    tok[n] = '{CL_DOT, poff_reg, 8'd1, 1'b0};
                    n = n + 2'd1;
                end
            end else if (psym_reg != 8'd0) begin
                if (c == pair_second(psym_reg)) begin
                    tok[n] = '{single_class(psym_reg) + 6'd1, poff_reg, 8'd2, 1'b0};
                    n = n + 2'd1;
                    consumed = 1'b1;
                end else begin
                    tok[n] = '{single_class(psym_reg), poff_reg, 8'd1, 1'b0};
                    n = n + 2'd1;
                end
            end
            psym_next = 8'd0;
            if (!consumed) begin
                if (c == 8'h22 || c == 8'h27 || is_space(c)) begin
                    if (w.len != 8'd0) begin
                        tok[n] = '{word_class(w), w.start, w.len, 1'b0};
                        n = n + 2'd1;
                        w = word_clear();
                    end
                    if (!is_space(c)) begin
                        mode_next = (c == 8'h22) ? MODE_TEXT : MODE_LETTER;
                        qlen_next = 8'd0;
                        qstart_next = pos_reg + 32'd1;
                    end
                end else if (is_alpha(c) || is_digit(c)) begin
                    w = add_char(w, c, pos_reg, WLIM);
                end else if (c == ".") begin
                    psym_next = c;
                    poff_next = pos_reg;
                end else if (pair_second(c) != 8'd0) begin
                    if (w.len != 8'd0) begin
                        tok[n] = '{word_class(w), w.start, w.len, 1'b0};
                        n = n + 2'd1;
                        w = word_clear();
                    end
                    psym_next = c;
                    poff_next = pos_reg;
                end else if (single_class(c) != CL_IDENT) begin
                    if (w.len != 8'd0) begin
                        tok[n] = '{word_class(w), w.start, w.len, 1'b0};
                        n = n + 2'd1;
                        w = word_clear();
                    end
                    tok[n] = '{single_class(c), pos_reg, 8'd1, 1'b0};
                    n = n + 2'd1;
                end else begin
                    mode_next = MODE_HALT;
                    tok[n] = '{CL_ERROR, pos_reg, 8'd1, 1'b0};
                    n = n + 2'd1;
                end
            end
            pos_next = pos_reg + 32'd1;
        end
        if (n != 2'd0) begin
            tok[n - 2'd1].last = 1'b1;
        end
        word_next = w;
        tok_cnt = n;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg   <= MODE_NORMAL;
            psym_reg   <= 8'd0;
            poff_reg   <= 32'd0;
            word_reg   <= word_clear();
            qlen_reg   <= 8'd0;
            qstart_reg <= 32'd0;
            pos_reg    <= 32'd0;
        end else if (fire) begin
            mode_reg   <= mode_next;
            psym_reg   <= psym_next;
            poff_reg   <= poff_next;
            word_reg   <= word_next;
            qlen_reg   <= qlen_next;
            qstart_reg <= qstart_next;
            pos_reg    <= pos_next;
        end
    end

`ifndef ASSERT_OFF
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_HALT |=> mode_reg == MODE_HALT)
        else $error("halt left");
    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_HALT |-> tok_cnt == 2'd0)
        else $error("token while halted");
    a_word_limit: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, word_reg.len} < WLIM)
        else $error("word length over limit");
`endif

endmodule

// File: hw/rtl/csl_outq.sv
// Token buffer: holds up to three tokens of one word and sends one per cycle while out_ready is high.
`timescale 1ns / 1ps
module csl_outq
    import csl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  token_t     tok [TOK_SLOTS],
    input  logic [1:0] tok_cnt,
    input  logic       out_ready,
    output logic       out_valid,
    output logic       can_load,
    output token_t     head
);

    token_t     slot_reg [TOK_SLOTS];
    logic [1:0] cnt_reg;
    logic       pop;

    assign out_valid = cnt_reg != 2'd0;
    assign pop       = out_valid && out_ready;
    assign can_load  = cnt_reg == 2'd0 || (cnt_reg == 2'd1 && out_ready);
    assign head      = slot_reg[0];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cnt_reg <= 2'd0;
        end else if (load) begin
            cnt_reg <= tok_cnt;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            for (int i = 0; i < TOK_SLOTS; i++) begin
                slot_reg[i] <= tok[i];
            end
        end else if (pop) begin
            for (int i = 0; i < TOK_SLOTS - 1; i++) begin
                slot_reg[i] <= slot_reg[i + 1];
            end
        end
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3 || !can_load)
        else $error("load allowed while full");
    a_load_safe: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop))
        else $error("load over pending tokens");
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd1 |-> slot_reg[0].last)
        else $error("final token lacks last mark");
`endif

endmodule

// File: hw/rtl/c_subset_lexer.sv
// Top level of the streaming lexer: decode core and token buffer.
// Tokens of an accepted byte word are registered in the token buffer before they leave.
// Throughput: one word per cycle while each word yields at most one token and out_ready
// is high; a word that yields more keeps in_ready low until its last token is being sent.
// Reset: rst_n clears lexer state and empties the token buffer at once.
`timescale 1ns / 1ps
module c_subset_lexer
    import csl_pkg::*;
#(
    parameter int WORD_MAX  = WORD_MAX_DEF,
    parameter int QUOTE_MAX = QUOTE_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  token_class,
    output logic [31:0] start_offset,
    output logic [7:0]  lexeme_length,
    output logic        last_of_run
);

    token_t     tok [TOK_SLOTS];
    token_t     head;
    logic [1:0] tok_cnt;
    logic       can_load;
    logic       fire;

    assign in_ready = can_load;
    assign fire     = in_valid && can_load;

    csl_core #(.WORD_MAX(WORD_MAX), .QUOTE_MAX(QUOTE_MAX)) u_core (
        .clk(clk), .rst_n(rst_n), .fire(fire), .kind(kind), .data_byte(data_byte),
        .tok(tok), .tok_cnt(tok_cnt)
    );

    csl_outq u_outq (
        .clk(clk), .rst_n(rst_n), .load(fire), .tok(tok), .tok_cnt(tok_cnt),
        .out_ready(out_ready), .out_valid(out_valid), .can_load(can_load), .head(head)
    );

    assign token_class   = head.cls;
    assign start_offset  = head.start;
    assign lexeme_length = head.len;
    assign last_of_run   = head.last;

endmodule
